/* rtl/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  // Default geometry of the queue.
  localparam int unsigned DEPTH_DEF      = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed widths of the stream fields.
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ITEM_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OCC_W      = 6;
  localparam int unsigned M_FIELDS_W = ITEM_W + OCC_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Operation codes carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP_FWD   = 3'd4,
    OP_DUMP_BWD   = 3'd5
  } op_e;

  // Result status carried on the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD  = 3'd0,
    CMD_SHR   = 3'd1,
    CMD_SHL   = 3'd2,
    CMD_PUSHB = 3'd3,
    CMD_ROTL  = 3'd4,
    CMD_ROTR  = 3'd5
  } cell_cmd_e;

  // Per-cell control: the shared command plus the cell's position flags.
  typedef struct packed {
    cell_cmd_e cmd;
    logic      in_use;    // cell holds a queued entry
    logic      is_tail;   // cell holds the back entry
    logic      is_next;   // first free cell behind the back entry
    logic      is_first;  // cell holds the front entry position
  } cell_ctl_t;

endpackage

/* rtl/bdeq_cell.sv */
// ----------------------------------------------------------------------------
// bdeq_cell
// One storage cell of the queue chain; shifts, rotates or loads its entry.
// ----------------------------------------------------------------------------
module bdeq_cell
  import bdeq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  cell_ctl_t             ctl_i,
  input  logic [DATA_WIDTH-1:0] left_i,   // entry of the neighbor nearer the front
  input  logic [DATA_WIDTH-1:0] right_i,  // entry of the neighbor nearer the back
  input  logic [DATA_WIDTH-1:0] wrap_i,   // entry that wraps around during a rotation
  input  logic [DATA_WIDTH-1:0] value_i,  // value of a push at the back
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  // Next entry of this cell from the broadcast command.
  always_comb begin
    data_d = data_q;
    unique case (ctl_i.cmd)
      CMD_SHR: begin
        data_d = left_i;
      end
      CMD_SHL: begin
        data_d = right_i;
      end
      CMD_PUSHB: begin
        if (ctl_i.is_next) begin
          data_d = value_i;
        end
      end
      CMD_ROTL: begin
        if (ctl_i.is_tail) begin
          data_d = wrap_i;
        end else if (ctl_i.in_use) begin
          data_d = right_i;
        end
      end
      CMD_ROTR: begin
        if (ctl_i.in_use) begin
          data_d = ctl_i.is_first ? wrap_i : left_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // Entry storage; its contents are only read while the cell is in use.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/bounded_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of fixed capacity built as a chain of storage cells.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction on s_axis carries the operation on tuser and the value
// to push on tdata. Every accepted operation except the unused codes six and
// seven yields results on m_axis: tdata holds the item value and the
// occupancy after the operation, tuser the status, tlast marks the final
// result of the operation.
// Cell 0 always holds the front entry. A push at the front shifts the whole
// chain one cell toward the back, a pop at the front shifts it toward the
// front, and the back entry is the cell selected by the entry count.
// The result of a push or pop is registered and appears in the cycle after
// the input transaction; with the receiver ready and no dump running, one
// operation is taken per cycle. A dump emits one entry per cycle while the
// receiver is ready, by rotating the occupied cells; it takes no input until
// its last entry is emitted, and it leaves the chain as it found it.
// Reset empties the queue and clears the output valid flag. When the receiver
// stalls, the pending result holds and no further input is taken.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
  import bdeq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [VALUE_W-1:0]   s_axis_tdata,   // [31:0] value
  input  logic [OP_W-1:0]      s_axis_tuser,   // [2:0] operation
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] item_value, [37:32] occupancy
  output logic [STATUS_W-1:0]  m_axis_tuser,   // [1:0] status
  output logic                 m_axis_tlast
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      dump_cnt_q, dump_cnt_d;
  logic                  dump_bwd_q, dump_bwd_d;

  logic                  out_valid_q;
  logic [ITEM_W-1:0]     out_item_q;
  status_e               out_status_q;
  logic                  out_last_q;
  logic [OCC_W-1:0]      out_occ_q;

  logic                  out_free;
  logic                  in_accept;
  op_e                   op;
  logic                  full, empty;
  logic                  emit;
  logic [ITEM_W-1:0]     emit_item;
  status_e               emit_status;
  logic                  emit_last;

  cell_cmd_e             cmd;
  cell_ctl_t             ctl [DEPTH];
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] head_data, tail_data, wrap_data, value_ext;

  // Handshake and decode.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign full          = (count_q == CNT_W'(DEPTH));
  assign empty         = (count_q == '0);
  assign value_ext     = DATA_WIDTH'(s_axis_tdata);

  // Front and back entries of the chain.
  assign head_data = cell_data[0];
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ctl[i].is_tail) begin
        tail_data = tail_data | cell_data[i];
      end
    end
  end
  assign wrap_data = (cmd == CMD_ROTR) ? tail_data : head_data;

  // Operation sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dump_cnt_d  = dump_cnt_q;
    dump_bwd_d  = dump_bwd_q;
    cmd         = CMD_HOLD;
    emit        = 1'b0;
    emit_item   = '0;
    emit_status = ST_OK;
    emit_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          unique case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              emit = 1'b1;
              if (full) begin
                emit_status = ST_FULL;
              end else begin
                cmd     = (op == OP_PUSH_FRONT) ? CMD_SHR : CMD_PUSHB;
                count_d = count_q + 1'b1;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = ST_EMPTY;
              end else begin
                if (op == OP_POP_FRONT) begin
                  cmd       = CMD_SHL;
                  emit_item = ITEM_W'(head_data);
                end else begin
                  emit_item = ITEM_W'(tail_data);
                end
                count_d = count_q - 1'b1;
              end
            end
            OP_DUMP_FWD, OP_DUMP_BWD: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                state_d    = S_DUMP;
                dump_cnt_d = count_q;
                dump_bwd_d = (op == OP_DUMP_BWD);
              end
            end
            default: begin
              // Unused operation codes give no result.
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_item  = ITEM_W'(dump_bwd_q ? tail_data : head_data);
          emit_last  = (dump_cnt_q == CNT_W'(1));
          cmd        = dump_bwd_q ? CMD_ROTR : CMD_ROTL;
          dump_cnt_d = dump_cnt_q - 1'b1;
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Chain of storage cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;

    assign ctl[i].cmd      = cmd;
    assign ctl[i].in_use   = (CNT_W'(i) < count_q);
    assign ctl[i].is_tail  = (CNT_W'(i + 1) == count_q);
    assign ctl[i].is_next  = (CNT_W'(i) == count_q);
    assign ctl[i].is_first = 1'(i == 0);

    if (i == 0) begin : g_left_push
      assign left_data = value_ext;
    end else begin : g_left_cell
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_self
      assign right_data = cell_data[i];
    end else begin : g_right_cell
      assign right_data = cell_data[i+1];
    end

    bdeq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[i]),
      .left_i (left_data),
      .right_i(right_data),
      .wrap_i (wrap_data),
      .value_i(value_ext),
      .data_o (cell_data[i])
    );
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      dump_cnt_q <= '0;
      dump_bwd_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dump_cnt_q <= dump_cnt_d;
      dump_bwd_q <= dump_bwd_d;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q   <= emit_item;
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
      out_occ_q    <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_occ_q, out_item_q});
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // The entry count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // No input transaction is taken while a dump is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> !s_axis_tready)
    else $error("input taken during dump");

  // The dump counter stays within the stored entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> (dump_cnt_q != '0) && (dump_cnt_q <= count_q))
    else $error("dump counter out of range");

  // A dump leaves the entry count unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |=> count_q == $past(count_q))
    else $error("entry count changed during dump");

endmodule
